FILE: sv/lagrange_extirpolation_grid_defines.svh
// assertion macros shared by the rtl
`ifndef LAGRANGE_EXTIRPOLATION_GRID_DEFINES_SVH
`define LAGRANGE_EXTIRPOLATION_GRID_DEFINES_SVH

// condition that must hold at every edge out of reset
`define LAGEXT_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("lagext invariant violated");

// consequence that must hold in the cycle after the antecedent
`define LAGEXT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lagext sequence violated");

`endif

FILE: sv/lagext_pkg.sv
`default_nettype none
package lagext_pkg;

   localparam int GRID_DEPTH_DEF = 4096;
   localparam int MAX_SPREAD     = 10;

   localparam int KIND_W   = 2;
   localparam int SAMPLE_W = 32;
   localparam int POS_W    = 29;
   localparam int INDEX_W  = 13;
   localparam int CELL_W   = 48;
   localparam int STATUS_W = 2;
   localparam int SPREAD_W = 4;

   localparam logic [KIND_W-1:0] KIND_SPREAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   localparam logic [INDEX_W-1:0]  GRID_SIZE_RST     = 13'd4096;
   localparam logic [SPREAD_W-1:0] SPREAD_POINTS_RST = 4'd4;

   localparam logic [0:0] REG_GRID_SIZE     = 1'b0;
   localparam logic [0:0] REG_SPREAD_POINTS = 1'b1;

   function automatic logic [18:0] fact(input logic [3:0] idx);
      logic [18:0] r;
      unique case (idx)
         4'd0:    r = 19'd1;
         4'd1:    r = 19'd1;
         4'd2:    r = 19'd2;
         4'd3:    r = 19'd6;
         4'd4:    r = 19'd24;
         4'd5:    r = 19'd120;
         4'd6:    r = 19'd720;
         4'd7:    r = 19'd5040;
         4'd8:    r = 19'd40320;
         4'd9:    r = 19'd362880;
         default: r = 19'd1;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: sv/lagext_if.sv
`default_nettype none
interface lagext_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [lagext_pkg::KIND_W-1:0]        kind;
   logic signed [lagext_pkg::SAMPLE_W-1:0] sample_value;
   logic [lagext_pkg::POS_W-1:0]         position;
   logic [lagext_pkg::INDEX_W-1:0]       read_index;
   modport source (output valid, kind, sample_value, position, read_index, input ready);
   modport sink (input valid, kind, sample_value, position, read_index, output ready);
endinterface

interface lagext_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lagext_pkg::CELL_W-1:0] cell_value;
   logic [lagext_pkg::STATUS_W-1:0]      status;
   modport source (output valid, cell_value, status, input ready);
   modport sink (input valid, cell_value, status, output ready);
endinterface
`default_nettype wire

FILE: sv/lagext_ram.sv
`default_nettype none
module lagext_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

FILE: sv/lagrange_extirpolation_grid.sv
// channel  dir  transfer when                 payload
// req      in   req.valid && req.ready         kind, sample_value, position, read_index
// rsp      out  rsp.valid && rsp.ready         cell_value, status
// csr      in   psel && penable && pwrite      grid_size @0x0, spread_points @0x4
//
// one item at a time; a spread works through its m window cells in turn on the
// shared 32x32 multiplier and the 57-step restoring divider
// a whole-numbered spread passes S_WAIT and S_ADD, a read S_RD_WAIT and S_RD_TAKE
// after reset a clearing pass over all GRID_DEPTH cells runs before req.ready rises
// a result waits in the output register until rsp.ready; req stalls meanwhile
`default_nettype none
`include "lagrange_extirpolation_grid_defines.svh"
module lagrange_extirpolation_grid #(
   parameter int GRID_DEPTH = lagext_pkg::GRID_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   lagext_req_if.sink        req,
   lagext_rsp_if.source      rsp,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [2:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   localparam int AW = $clog2(GRID_DEPTH);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WAIT, S_RD_WAIT, S_RD_TAKE, S_SETUP, S_CELL_INIT, S_K,
      S_MUL_LO, S_MUL_HI, S_DEN, S_DIV, S_MQ_LO, S_MQ_HI, S_ADD, S_RESP
   } state_type;

   state_type state_ff;
   logic [lagext_pkg::INDEX_W-1:0]  grid_size_ff;
   logic [lagext_pkg::SPREAD_W-1:0] spread_ff;
   logic [AW-1:0]   clr_ff;
   logic            clr_resp_ff;
   logic            whole_ff;
   logic            sat_ff;
   logic            neg_ff;
   logic [28:0]     pos_ff;
   logic [31:0]     ylen_ff;
   logic            yneg_ff;
   logic [13:0]     cell_ff, lo_ff, hi_ff, k_ff;
   logic [20:0]     b_ff;
   logic [55:0]     acc_ff;
   logic [36:0]     plo_ff;
   logic [18:0]     den_ff;
   logic [19:0]     rem_ff;
   logic [56:0]     q_ff;
   logic [5:0]      cnt_ff;
   logic [56:0]     c_ff;
   logic            rsp_valid_ff;
   logic [47:0]     rsp_value_ff;
   logic [1:0]      rsp_status_ff;

   logic [16:0]     n17;
   logic [13:0]     n;
   logic [3:0]      m;
   logic [31:0]     mul_a, mul_b;
   logic [63:0]     prod;
   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   logic [47:0]     ram_wdata, ram_rdata;
   logic [AW-1:0]   ram_raddr;
   logic signed [30:0] t;
   logic [13:0]     lo_raw, lo_max;
   logic signed [30:0] d;
   logic [19:0]     trial;
   logic signed [58:0] sum;
   logic            clamp_hi, clamp_lo;
   logic [47:0]     sum_sat;
   logic            accept;
   logic [31:0]     ylen_in;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.cell_value = rsp_value_ff;
   assign rsp.status = rsp_status_ff;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == lagext_pkg::REG_SPREAD_POINTS) ? {28'd0, spread_ff}
                                                               : {19'd0, grid_size_ff};

   always_comb begin
      if (grid_size_ff < 13'd16) begin
         n17 = 17'd16;
      end else if ({4'd0, grid_size_ff} > 17'(GRID_DEPTH)) begin
         n17 = 17'(GRID_DEPTH);
      end else begin
         n17 = {4'd0, grid_size_ff};
      end
      n = 14'(n17);
      if (spread_ff == 4'd0) begin
         m = 4'd1;
      end else if (spread_ff > 4'(lagext_pkg::MAX_SPREAD)) begin
         m = 4'(lagext_pkg::MAX_SPREAD);
      end else begin
         m = spread_ff;
      end
   end

   always_comb begin
      t = $signed({2'b00, pos_ff}) + 31'sd65536 - $signed({12'd0, m, 15'd0});
      lo_raw = t[30] ? 14'd1 : t[29:16];
      lo_max = n - {10'd0, m} + 14'd1;
      d = $signed({2'b00, pos_ff}) - $signed({1'b0, k_ff, 16'd0});
      trial = {rem_ff[18:0], q_ff[56]};
      sum = $signed({{11{ram_rdata[47]}}, ram_rdata})
          + (neg_ff ? -$signed({2'b00, c_ff}) : $signed({2'b00, c_ff}));
      clamp_hi = !sum[58] && (sum[57:47] != 11'd0);
      clamp_lo = sum[58] && (sum[57:47] != 11'h7FF);
      priority if (clamp_hi) begin
         sum_sat = 48'h7FFF_FFFF_FFFF;
      end else if (clamp_lo) begin
         sum_sat = 48'h8000_0000_0000;
      end else begin
         sum_sat = sum[47:0];
      end
      ylen_in = req.sample_value[31] ? 32'(-req.sample_value) : 32'(req.sample_value);
   end

   always_comb begin
      unique case (state_ff)
         S_MUL_LO: begin
            mul_a = acc_ff[31:0];
            mul_b = {11'd0, b_ff};
         end
         S_MUL_HI: begin
            mul_a = {8'd0, acc_ff[55:32]};
            mul_b = {11'd0, b_ff};
         end
         S_DEN: begin
            mul_a = {13'd0, lagext_pkg::fact(4'(cell_ff - lo_ff))};
            mul_b = {13'd0, lagext_pkg::fact(4'(hi_ff - cell_ff))};
         end
         S_MQ_LO: begin
            mul_a = ylen_ff;
            mul_b = q_ff[31:0];
         end
         S_MQ_HI: begin
            mul_a = ylen_ff;
            mul_b = {7'd0, q_ff[56:32]};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
      prod = 64'(mul_a) * 64'(mul_b);
   end

   always_comb begin
      ram_raddr = AW'(cell_ff - 14'd1);
      if (state_ff == S_CLEAR) begin
         ram_we = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = 48'd0;
      end else begin
         ram_we = (state_ff == S_ADD);
         ram_waddr = ram_raddr;
         ram_wdata = sum_sat;
      end
   end

   lagext_ram #(.WIDTH(lagext_pkg::CELL_W), .DEPTH(GRID_DEPTH)) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         clr_resp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         grid_size_ff <= lagext_pkg::GRID_SIZE_RST;
         spread_ff <= lagext_pkg::SPREAD_POINTS_RST;
      end else begin
         if (psel && penable && pwrite) begin
            if (paddr[2] == lagext_pkg::REG_GRID_SIZE) begin
               grid_size_ff <= pwdata[12:0];
            end else begin
               spread_ff <= pwdata[3:0];
            end
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(GRID_DEPTH - 1)) begin
                  if (clr_resp_ff) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_IDLE: begin
               if (accept) begin
                  rsp_value_ff <= '0;
                  rsp_status_ff <= lagext_pkg::STATUS_OK;
                  sat_ff <= 1'b0;
                  pos_ff <= req.position;
                  ylen_ff <= ylen_in;
                  yneg_ff <= req.sample_value[31];
                  priority case (req.kind)
                     lagext_pkg::KIND_SPREAD: begin
                        if (req.position < 29'd65536 ||
                            {1'b0, req.position} >= {n + 14'd1, 16'd0}) begin
                           rsp_status_ff <= lagext_pkg::STATUS_RANGE;
                           rsp_valid_ff <= 1'b1;
                           state_ff <= S_RESP;
                        end else if (req.position[15:0] == 16'd0) begin
                           whole_ff <= 1'b1;
                           cell_ff <= {1'b0, req.position[28:16]};
                           neg_ff <= req.sample_value[31];
                           c_ff <= {25'd0, ylen_in};
                           state_ff <= S_WAIT;
                        end else begin
                           whole_ff <= 1'b0;
                           state_ff <= S_SETUP;
                        end
                     end
                     lagext_pkg::KIND_READ: begin
                        if (req.read_index == 13'd0 || {1'b0, req.read_index} > n) begin
                           rsp_status_ff <= lagext_pkg::STATUS_RANGE;
                           rsp_valid_ff <= 1'b1;
                           state_ff <= S_RESP;
                        end else begin
                           cell_ff <= {1'b0, req.read_index};
                           state_ff <= S_RD_WAIT;
                        end
                     end
                     lagext_pkg::KIND_CLEAR: begin
                        clr_ff <= '0;
                        clr_resp_ff <= 1'b1;
                        state_ff <= S_CLEAR;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end
            S_WAIT: state_ff <= S_ADD;
            S_RD_WAIT: state_ff <= S_RD_TAKE;
            S_RD_TAKE: begin
               rsp_value_ff <= ram_rdata;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_RESP;
            end
            S_SETUP: begin
               if (lo_raw > lo_max) begin
                  lo_ff <= lo_max;
                  hi_ff <= lo_max + {10'd0, m} - 14'd1;
                  cell_ff <= lo_max;
               end else if (lo_raw == 14'd0) begin
                  lo_ff <= 14'd1;
                  hi_ff <= {10'd0, m};
                  cell_ff <= 14'd1;
               end else begin
                  lo_ff <= lo_raw;
                  hi_ff <= lo_raw + {10'd0, m} - 14'd1;
                  cell_ff <= lo_raw;
               end
               state_ff <= S_CELL_INIT;
            end
            S_CELL_INIT: begin
               acc_ff <= 56'd1 << 32;
               neg_ff <= yneg_ff;
               k_ff <= lo_ff;
               state_ff <= S_K;
            end
            S_K: begin
               if (k_ff > hi_ff) begin
                  state_ff <= S_DEN;
               end else if (k_ff == cell_ff) begin
                  k_ff <= k_ff + 14'd1;
               end else begin
                  if (d[30]) begin
                     neg_ff <= !neg_ff;
                     b_ff <= 21'(-d);
                  end else begin
                     b_ff <= 21'(d);
                  end
                  state_ff <= S_MUL_LO;
               end
            end
            S_MUL_LO: begin
               plo_ff <= 37'((prod + 64'h8000) >> 16);
               state_ff <= S_MUL_HI;
            end
            S_MUL_HI: begin
               acc_ff <= 56'({prod[39:0], 16'd0}) + 56'(plo_ff);
               k_ff <= k_ff + 14'd1;
               state_ff <= S_K;
            end
            S_DEN: begin
               den_ff <= prod[18:0];
               q_ff <= 57'(acc_ff) + 57'(prod[18:1]);
               rem_ff <= '0;
               cnt_ff <= '0;
               if (hi_ff[0] != cell_ff[0]) begin
                  neg_ff <= !neg_ff;
               end
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (trial >= {1'b0, den_ff}) begin
                  rem_ff <= trial - {1'b0, den_ff};
                  q_ff <= {q_ff[55:0], 1'b1};
               end else begin
                  rem_ff <= trial;
                  q_ff <= {q_ff[55:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd56) begin
                  state_ff <= S_MQ_LO;
               end
            end
            S_MQ_LO: begin
               plo_ff <= 37'(({1'b0, prod} + 65'h8000_0000) >> 32);
               state_ff <= S_MQ_HI;
            end
            S_MQ_HI: begin
               c_ff <= 57'(prod) + 57'(plo_ff);
               state_ff <= S_ADD;
            end
            S_ADD: begin
               if (clamp_hi || clamp_lo) begin
                  sat_ff <= 1'b1;
               end
               if (whole_ff || cell_ff == hi_ff) begin
                  rsp_status_ff <= (sat_ff || clamp_hi || clamp_lo) ? lagext_pkg::STATUS_SAT
                                                                    : lagext_pkg::STATUS_OK;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_RESP;
               end else begin
                  cell_ff <= cell_ff + 14'd1;
                  state_ff <= S_CELL_INIT;
               end
            end
            S_RESP: begin
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  clr_resp_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `LAGEXT_ASSERT_ALWAYS(a_no_overlap, !(req.ready && rsp.valid))
   `LAGEXT_ASSERT_NEXT(a_busy_after_accept, accept, !req.ready)
   `LAGEXT_ASSERT_ALWAYS(a_no_write_idle, !(state_ff == S_IDLE && ram_we))
   `LAGEXT_ASSERT_ALWAYS(a_rem_below_den, !(state_ff == S_DIV) || (rem_ff < {1'b0, den_ff}))
endmodule
`default_nettype wire

FILE: test/lagrange_extirpolation_grid_tb.sv
`default_nettype none
module lagrange_extirpolation_grid_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lagext_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int DEPTH = lagext_pkg::GRID_DEPTH_DEF;
   localparam int STALL_LIMIT = 20000;
   localparam longint CELL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint CELL_MIN = -64'sh0000_8000_0000_0000;
   localparam longint unsigned FACTORIAL [10] =
      '{1, 1, 2, 6, 24, 120, 720, 5040, 40320, 362880};

   typedef struct {
      logic [lagext_pkg::KIND_W-1:0]          kind;
      logic signed [lagext_pkg::SAMPLE_W-1:0] sample;
      logic [lagext_pkg::POS_W-1:0]           pos;
      logic [lagext_pkg::INDEX_W-1:0]         index;
   } grid_op_type;

   typedef struct {
      logic signed [lagext_pkg::CELL_W-1:0] value;
      logic [lagext_pkg::STATUS_W-1:0]      status;
   } cell_result_type;

   typedef struct {
      grid_op_type     op;
      bit              typed;
      cell_result_type result;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel, penable, pwrite, pready;
   logic [2:0] paddr;
   logic [31:0] pwdata, prdata;

   lagext_req_if req();
   lagext_rsp_if rsp();

   lagrange_extirpolation_grid DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   longint grid_model [DEPTH];
   logic [lagext_pkg::INDEX_W-1:0]  cfg_grid;
   logic [lagext_pkg::SPREAD_W-1:0] cfg_spread;
   cell_result_type pending_results [$];
   int err_count = 0;
   int n_spread = 0, n_read = 0, n_clear = 0, n_sat = 0, n_range = 0, n_phase = 0;
   bit quiet = 1'b0;
   int rsp_stall = 0;
   int idle_cycles = 0;

   function automatic longint unsigned eff_grid();
      longint unsigned n;
      n = cfg_grid;
      if (n < 16) n = 16;
      if (n > DEPTH) n = DEPTH;
      return n;
   endfunction

   function automatic longint unsigned eff_spread();
      longint unsigned m;
      m = cfg_spread;
      if (m < 1) m = 1;
      if (m > lagext_pkg::MAX_SPREAD) m = lagext_pkg::MAX_SPREAD;
      return m;
   endfunction

   function automatic bit accumulate_cell(longint unsigned idx, longint v);
      longint s;
      s = grid_model[idx-1] + v;
      if (s > CELL_MAX) begin
         grid_model[idx-1] = CELL_MAX;
         return 1'b1;
      end
      if (s < CELL_MIN) begin
         grid_model[idx-1] = CELL_MIN;
         return 1'b1;
      end
      grid_model[idx-1] = s;
      return 1'b0;
   endfunction

   function automatic longint unsigned scale_q16(longint unsigned a, longint unsigned b);
      longint unsigned hi, lo;
      hi = a >> 32;
      lo = a & 64'hFFFF_FFFF;
      return ((hi * b) << 16) + ((lo * b + 64'h8000) >> 16);
   endfunction

   function automatic longint unsigned scale_q32(longint unsigned y, longint unsigned w);
      longint unsigned hi, lo;
      hi = w >> 32;
      lo = w & 64'hFFFF_FFFF;
      return y * hi + ((y * lo + 64'h8000_0000) >> 32);
   endfunction

   function automatic logic [lagext_pkg::STATUS_W-1:0] spread_sample(
         logic [lagext_pkg::POS_W-1:0] pos, logic signed [lagext_pkg::SAMPLE_W-1:0] y);
      longint unsigned n, m, p, ymag, lo, hi, acc, den, w, c;
      longint t, d, yl;
      bit neg, sat;
      n = eff_grid();
      m = eff_spread();
      p = pos;
      yl = y;
      ymag = (yl < 0) ? -yl : yl;
      sat = 1'b0;
      if (p < 65536 || p >= ((n + 1) << 16)) return lagext_pkg::STATUS_RANGE;
      if (pos[15:0] == 16'd0) begin
         return accumulate_cell(p >> 16, yl) ? lagext_pkg::STATUS_SAT : lagext_pkg::STATUS_OK;
      end
      t = longint'(p) + 65536 - longint'(m) * 32768;
      lo = (t < 0) ? 1 : (t >> 16);
      if (lo < 1) lo = 1;
      if (lo > n - m + 1) lo = n - m + 1;
      hi = lo + m - 1;
      for (longint unsigned j = lo; j <= hi; j++) begin
         acc = 64'd1 << 32;
         neg = (yl < 0);
         for (longint unsigned k = lo; k <= hi; k++) begin
            if (k != j) begin
               d = longint'(p) - longint'(k << 16);
               if (d < 0) begin
                  neg = !neg;
                  acc = scale_q16(acc, -d);
               end else begin
                  acc = scale_q16(acc, d);
               end
            end
         end
         den = FACTORIAL[(j - lo) % 10] * FACTORIAL[(hi - j) % 10];
         if ((hi - j) & 1) neg = !neg;
         w = (acc + den / 2) / den;
         c = scale_q32(ymag, w);
         if (accumulate_cell(j, neg ? -longint'(c) : longint'(c))) sat = 1'b1;
      end
      return sat ? lagext_pkg::STATUS_SAT : lagext_pkg::STATUS_OK;
   endfunction

   function automatic cell_result_type predict_grid_op(grid_op_type op);
      cell_result_type r;
      r.value = '0;
      r.status = lagext_pkg::STATUS_OK;
      case (op.kind)
         lagext_pkg::KIND_SPREAD: begin
            r.status = spread_sample(op.pos, op.sample);
            n_spread++;
         end
         lagext_pkg::KIND_READ: begin
            n_read++;
            if (op.index < 1 || op.index > eff_grid()) r.status = lagext_pkg::STATUS_RANGE;
            else r.value = grid_model[op.index-1][lagext_pkg::CELL_W-1:0];
         end
         lagext_pkg::KIND_CLEAR: begin
            n_clear++;
            foreach (grid_model[i]) grid_model[i] = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic grid_op_type random_grid_op();
      grid_op_type op;
      longint unsigned n;
      int r;
      n = eff_grid();
      op.kind = lagext_pkg::KIND_SPREAD;
      op.sample = $urandom;
      op.pos = $urandom;
      op.index = $urandom;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         op.kind = lagext_pkg::KIND_SPREAD;
         case ($urandom_range(0, 3))
            0: op.sample = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            1: op.sample = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: op.sample = $urandom;
         endcase
         r = $urandom_range(0, 99);
         if (r < 8) begin
            case ($urandom_range(0, 2))
               0: op.pos = $urandom_range(0, 65535);
               1: op.pos = $urandom_range((n + 1) << 16, (1 << lagext_pkg::POS_W) - 1);
               default: op.pos = $urandom;
            endcase
         end else if (r < 20) begin
            op.pos = $urandom_range(1, n) << 16;
         end else begin
            op.pos = $urandom_range(65536, ((n + 1) << 16) - 1);
         end
      end else if (r < 93) begin
         op.kind = lagext_pkg::KIND_READ;
         if ($urandom_range(0, 9) != 0) op.index = $urandom_range(1, n);
      end else if (r < 95) begin
         op.kind = lagext_pkg::KIND_CLEAR;
      end else begin
         op.kind = KIND_UNUSED;
      end
      return op;
   endfunction

   task automatic issue_op(grid_op_type op, bit typed, cell_result_type typed_result);
      cell_result_type r;
      int gap;
      req.valid <= 1'b1;
      req.kind <= op.kind;
      req.sample_value <= op.sample;
      req.position <= op.pos;
      req.read_index <= op.index;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      r = predict_grid_op(op);
      pending_results.push_back(typed ? typed_result : r);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 19);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [0:0] reg_index, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(4 * reg_index);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_index == lagext_pkg::REG_GRID_SIZE) cfg_grid = value[lagext_pkg::INDEX_W-1:0];
      else cfg_spread = value[lagext_pkg::SPREAD_W-1:0];
   endtask

   task automatic configure(logic [31:0] grid, logic [31:0] points);
      drain_results();
      write_register(lagext_pkg::REG_GRID_SIZE, grid);
      write_register(lagext_pkg::REG_SPREAD_POINTS, points);
      n_phase++;
   endtask

   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp.ready <= 1'b1;
         if (!quiet && $urandom_range(0, 15) == 0) rsp_stall <= $urandom_range(1, 19);
      end
   end

   always @(posedge clock) begin
      cell_result_type exp_r;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected: cell_value %h status %0d",
                   rsp.cell_value, rsp.status);
            err_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp.status == lagext_pkg::STATUS_SAT) n_sat++;
            if (rsp.status == lagext_pkg::STATUS_RANGE) n_range++;
            if (rsp.cell_value !== exp_r.value) begin
               $error("cell_value expected %h actual %h", exp_r.value, rsp.cell_value);
               err_count++;
            end
            if (rsp.status !== exp_r.status) begin
               $error("status expected %0d actual %0d", exp_r.status, rsp.status);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic directed_row_type row(logic [lagext_pkg::KIND_W-1:0] kind,
                                            logic [31:0] sample,
                                            logic [lagext_pkg::POS_W-1:0] pos,
                                            logic [lagext_pkg::INDEX_W-1:0] index,
                                            bit typed,
                                            logic [lagext_pkg::CELL_W-1:0] exp_value,
                                            logic [lagext_pkg::STATUS_W-1:0] status);
      directed_row_type d;
      d.op.kind = kind;
      d.op.sample = sample;
      d.op.pos = pos;
      d.op.index = index;
      d.typed = typed;
      d.result.value = exp_value;
      d.result.status = status;
      return d;
   endfunction

   initial begin
      directed_row_type directed [$];
      grid_op_type op;
      cell_result_type none;
      int batch;
      none.value = '0;
      none.status = lagext_pkg::STATUS_OK;
      foreach (grid_model[i]) grid_model[i] = 0;
      cfg_grid = lagext_pkg::GRID_SIZE_RST;
      cfg_spread = lagext_pkg::SPREAD_POINTS_RST;
      req.valid = 1'b0;
      req.kind = lagext_pkg::KIND_SPREAD;
      req.sample_value = '0;
      req.position = '0;
      req.read_index = '0;
      rsp.ready = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(row(lagext_pkg::KIND_READ, 0, 0, 1, 1, 0, lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_READ, 0, 0, 0, 1, 0, lagext_pkg::STATUS_RANGE));
      directed.push_back(row(lagext_pkg::KIND_READ, 0, 0, 4096, 1, 0, lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_READ, 0, 0, 8191, 1, 0,
                             lagext_pkg::STATUS_RANGE));
      directed.push_back(row(KIND_UNUSED, '1, '1, '1, 1, 0, lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_SPREAD, 32'h0001_0000, 0, 0, 1, 0,
                             lagext_pkg::STATUS_RANGE));
      directed.push_back(row(lagext_pkg::KIND_SPREAD, 32'h0001_0000, 4097 << 16, 0, 1, 0,
                             lagext_pkg::STATUS_RANGE));
      directed.push_back(row(lagext_pkg::KIND_SPREAD, 32'h0001_0000, '1, 0, 1, 0,
                             lagext_pkg::STATUS_RANGE));
      directed.push_back(row(lagext_pkg::KIND_SPREAD, 32'h7FFF_FFFF, 1 << 16, 0, 0, 0,
                             lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_READ, 0, 0, 1, 1, 48'h7FFF_FFFF,
                             lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_SPREAD, 32'h8000_0000, 4096 << 16, 0, 0, 0,
                             lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_READ, 0, 0, 4096, 1, 48'hFFFF_8000_0000,
                             lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_SPREAD, 32'h0001_0000, 32'h0001_8000, 0, 0, 0,
                             lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_SPREAD, 32'hFFFF_0000,
                             (4096 << 16) + 16'hC000, 0, 0, 0, lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_SPREAD, 32'h1234_5678,
                             (2000 << 16) + 16'h8000, 0, 0, 0, lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_SPREAD, 32'h7FFF_FFFF, 32'h0001_0001, 0, 0, 0,
                             lagext_pkg::STATUS_OK));
      for (int i = 1; i <= 4; i++) begin
         directed.push_back(row(lagext_pkg::KIND_READ, 0, 0, i, 0, 0, lagext_pkg::STATUS_OK));
      end
      directed.push_back(row(lagext_pkg::KIND_READ, 0, 0, 4095, 0, 0, lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_READ, 0, 0, 2001, 0, 0, lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_CLEAR, 0, 0, 0, 1, 0, lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_READ, 0, 0, 1, 1, 0, lagext_pkg::STATUS_OK));
      directed.push_back(row(lagext_pkg::KIND_READ, 0, 0, 4096, 1, 0, lagext_pkg::STATUS_OK));
      foreach (directed[i]) issue_op(directed[i].op, directed[i].typed, directed[i].result);

      // drive the end cells into saturation with extrapolating weights
      configure(16, 10);
      for (int i = 0; i < 300; i++) begin
         op.kind = lagext_pkg::KIND_SPREAD;
         op.sample = (i < 150) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         op.pos = (17 << 16) - 1 - $urandom_range(0, 3);
         op.index = '0;
         issue_op(op, 0, none);
      end
      for (int i = 1; i <= 16; i++) begin
         op.kind = lagext_pkg::KIND_READ;
         op.index = i;
         issue_op(op, 0, none);
      end
      op.kind = lagext_pkg::KIND_CLEAR;
      issue_op(op, 0, none);

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: configure(0, 0);
            1: configure(4096, 10);
            2: configure(100, 3);
            3: configure(8191, 15);
            4: configure(37, 5);
            5: configure(16, 1);
            default: configure(4096, 2);
         endcase
         batch = (ph == 6) ? 250 : 215;
         if (ph == 6) quiet = 1'b1;
         for (int i = 0; i < batch; i++) issue_op(random_grid_op(), 0, none);
      end

      drain_results();
      repeat (50) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         err_count++;
      end
      $display("covered %0d spreads, %0d reads, %0d clears over %0d register settings",
               n_spread, n_read, n_clear, n_phase + 1);
      $display("saturating results %0d, out-of-range results %0d", n_sat, n_range);
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire
